>>> rtl/gbi_pkg.sv
`default_nettype none

package gbi_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;

   // Widths of the grid size registers and of a clamped cell index.
   localparam int SIZE_W = 7;
   localparam int IDX_W  = 6;

   // The store holds 4096 samples.
   localparam int ADDR_W = 12;
   localparam int DATA_W = 16;

   // Number of neighbours read for one query, and their read port order.
   localparam int NUM_TAPS = 4;
   localparam int TAP_LL   = 0;
   localparam int TAP_LR   = 1;
   localparam int TAP_UL   = 2;
   localparam int TAP_UR   = 3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_INV_SPACING_X = 3'd2,
      CSR_INV_SPACING_Y = 3'd3,
      CSR_COLS          = 3'd4,
      CSR_ROWS          = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                     req_type;
      logic [ADDR_W-1:0]        cell_index;
      logic signed [DATA_W-1:0] cell_value;
      logic signed [31:0]       longitude;
      logic signed [31:0]       latitude;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0] elevation;
      logic               inside_res;
   } rsp_payload_type;

   // Write and read requests from the pipeline to the grid store.
   typedef struct packed {
      logic                     wr_en;
      logic [ADDR_W-1:0]        wr_addr;
      logic signed [DATA_W-1:0] wr_data;
      logic                     rd_en;
   } store_ctl_type;

endpackage

`default_nettype wire

>>> rtl/gbi_store.sv
`default_nettype none

module gbi_store (
   input  wire logic                                              clock,
   input  wire gbi_pkg::store_ctl_type                            ctl,
   input  wire logic [gbi_pkg::NUM_TAPS-1:0][gbi_pkg::ADDR_W-1:0] rd_addr,
   output logic [gbi_pkg::NUM_TAPS-1:0][gbi_pkg::DATA_W-1:0]       rd_data
);
   import gbi_pkg::*;

   // One copy of the grid per neighbour: every copy takes every write and
   // serves one read, so all four neighbours come back in the same cycle.
   for (genvar t = 0; t < NUM_TAPS; t++) begin : g_copy
      logic [DATA_W-1:0] mem [1 << ADDR_W];
      logic [DATA_W-1:0] rd_data_ff;

      always_ff @(posedge clock) begin
         if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.rd_en) begin
            rd_data_ff <= mem[rd_addr[t]];
         end
      end

      assign rd_data[t] = rd_data_ff;
   end

endmodule

`default_nettype wire

>>> rtl/grid_bilinear_interpolator.sv
`default_nettype none

// Bilinear elevation lookup on a regular grid of signed 16-bit samples.
//
// The req_ channel carries two kinds of beat. A write beat stores one
// sample at cell_index and gives no response. A query beat gives exactly one
// rsp_ beat: the blended elevation with 8 fraction bits, or zero with
// inside_res low when the point falls outside the grid.
// The csr_ channel writes the origin, reciprocal spacing and grid size; it
// is always ready and should only be used while no query is in flight.
//
// The datapath is an eight-stage pipeline with a valid bit per stage, so a
// new beat can be taken on every clock unless all stages are full and the
// receiver stalls. Samples are read from four replicated copies of the
// store, one per neighbour; a write takes effect in pipeline order, so a
// query that follows a write sees the new sample.
// Each stage holds its beat while the stage after it is full and stalled,
// so a stalled receiver backs the pipeline up behind it, bubbles are
// squeezed out, and nothing is dropped or repeated.
// Reset clears all valid bits and restores the default registers; the
// store contents are undefined until written.

module grid_bilinear_interpolator (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire gbi_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output gbi_pkg::rsp_payload_type      rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [2:0]               csr_index,
   input  wire logic [31:0]              csr_wdata
);
   import gbi_pkg::*;

   localparam int NUM_STAGES = 8;

   // ---------------------------------------------------------------------
   // Configuration registers.
   // ---------------------------------------------------------------------
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic signed [31:0] inv_x_ff, inv_y_ff;
   logic [SIZE_W-1:0]  cols_ff, rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_x_ff    <= 32'sd65536;
         inv_y_ff    <= 32'sd65536;
         cols_ff     <= SIZE_W'(MAX_COLS);
         rows_ff     <= SIZE_W'(MAX_ROWS);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:      origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:      origin_y_ff <= csr_wdata;
            CSR_INV_SPACING_X: inv_x_ff    <= csr_wdata;
            CSR_INV_SPACING_Y: inv_y_ff    <= csr_wdata;
            CSR_COLS:          cols_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_ROWS:          rows_ff     <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero counts as one, and a size above the store's limit
   // saturates at that limit.
   logic [SIZE_W-1:0] nx, ny;

   always_comb begin
      nx = cols_ff;
      if (cols_ff == '0) begin
         nx = SIZE_W'(1);
      end else if (cols_ff > SIZE_W'(MAX_COLS)) begin
         nx = SIZE_W'(MAX_COLS);
      end
      ny = rows_ff;
      if (rows_ff == '0) begin
         ny = SIZE_W'(1);
      end else if (rows_ff > SIZE_W'(MAX_ROWS)) begin
         ny = SIZE_W'(MAX_ROWS);
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage loads when it is empty or when the
   // stage after it is moving on.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES:1] valid_ff, valid_in;
   logic [NUM_STAGES:1] load;

   always_comb begin
      load[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_ready = load[1];

   // Stage 1: input register.
   req_payload_type s1_ff;

   // Stage 2: offsets from the origin, exact in 33 bits.
   logic               s2_query_ff;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic signed [DATA_W-1:0] s2_value_ff;
   logic signed [32:0] s2_dx_ff, s2_dy_ff;
   logic signed [32:0] s2_dx_in, s2_dy_in;

   assign s2_dx_in = {s1_ff.longitude[31], s1_ff.longitude} - {origin_x_ff[31], origin_x_ff};
   assign s2_dy_in = {s1_ff.latitude[31], s1_ff.latitude} - {origin_y_ff[31], origin_y_ff};

   // Stage 3: grid positions in Q.16, floored (the arithmetic shift of the
   // exact Q.38 product rounds toward minus infinity).
   logic               s3_query_ff;
   logic [ADDR_W-1:0]  s3_addr_ff;
   logic signed [DATA_W-1:0] s3_value_ff;
   logic signed [42:0] s3_hx_ff, s3_hy_ff;
   logic signed [64:0] prod_x, prod_y;

   assign prod_x = s2_dx_ff * $signed({inv_x_ff[31], inv_x_ff});
   assign prod_y = s2_dy_ff * $signed({inv_y_ff[31], inv_y_ff});

   // Stage 4: inside test, clamped neighbour indices and fractions.
   logic               s4_query_ff;
   logic [ADDR_W-1:0]  s4_addr_ff;
   logic signed [DATA_W-1:0] s4_value_ff;
   logic               s4_inside_ff, s4_inside_in;
   logic [IDX_W-1:0]   s4_ix_ff, s4_iy_ff, s4_ix1_ff, s4_iy1_ff;
   logic [IDX_W-1:0]   s4_ix_in, s4_iy_in, s4_ix1_in, s4_iy1_in;
   logic [15:0]        s4_fx_ff, s4_fy_ff;
   logic [SIZE_W-1:0]  ix_raw, iy_raw, nx_m1, ny_m1;

   always_comb begin
      s4_inside_in = !s3_hx_ff[42] && !s3_hy_ff[42]
                     && (s3_hx_ff[41:0] <= {19'd0, nx, 16'd0})
                     && (s3_hy_ff[41:0] <= {19'd0, ny, 16'd0});
      // Only meaningful when inside, where the position is at most 2^22.
      ix_raw = s3_hx_ff[16 +: SIZE_W];
      iy_raw = s3_hy_ff[16 +: SIZE_W];
      nx_m1  = nx - SIZE_W'(1);
      ny_m1  = ny - SIZE_W'(1);
      s4_ix_in  = (ix_raw > nx_m1) ? nx_m1[IDX_W-1:0] : ix_raw[IDX_W-1:0];
      s4_iy_in  = (iy_raw > ny_m1) ? ny_m1[IDX_W-1:0] : iy_raw[IDX_W-1:0];
      s4_ix1_in = ({1'b0, s4_ix_in} >= nx_m1) ? nx_m1[IDX_W-1:0] : s4_ix_in + IDX_W'(1);
      s4_iy1_in = ({1'b0, s4_iy_in} >= ny_m1) ? ny_m1[IDX_W-1:0] : s4_iy_in + IDX_W'(1);
   end

   // Stage 4 to 5: store addresses (row * cols + column) and the store
   // access. A write leaves the pipeline here.
   logic [NUM_TAPS-1:0][ADDR_W-1:0] rd_addr;
   logic [NUM_TAPS-1:0][DATA_W-1:0] rd_data;
   store_ctl_type                   store_ctl;
   logic [ADDR_W:0] row_lo, row_hi;

   always_comb begin
      row_lo = (ADDR_W+1)'(s4_iy_ff * nx);
      row_hi = (ADDR_W+1)'(s4_iy1_ff * nx);
      rd_addr[TAP_LL] = ADDR_W'(row_lo + (ADDR_W+1)'(s4_ix_ff));
      rd_addr[TAP_LR] = ADDR_W'(row_lo + (ADDR_W+1)'(s4_ix1_ff));
      rd_addr[TAP_UL] = ADDR_W'(row_hi + (ADDR_W+1)'(s4_ix_ff));
      rd_addr[TAP_UR] = ADDR_W'(row_hi + (ADDR_W+1)'(s4_ix1_ff));
      store_ctl.wr_en   = valid_ff[4] && load[5] && !s4_query_ff;
      store_ctl.wr_addr = s4_addr_ff;
      store_ctl.wr_data = s4_value_ff;
      store_ctl.rd_en   = load[5];
   end

   gbi_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stage 5: samples come back from the store.
   logic        s5_inside_ff;
   logic [15:0] s5_fx_ff, s5_fy_ff;

   // Stage 6: blend along the columns.
   logic               s6_inside_ff;
   logic [15:0]        s6_fy_ff;
   logic signed [34:0] s6_top_ff, s6_bot_ff, s6_top_in, s6_bot_in;
   logic signed [17:0] wx_lo, wx_hi;

   always_comb begin
      wx_hi = $signed({2'b00, s5_fx_ff});
      wx_lo = 18'sh10000 - wx_hi;
      s6_top_in = 35'($signed(rd_data[TAP_LL]) * wx_lo)
                  + 35'($signed(rd_data[TAP_LR]) * wx_hi);
      s6_bot_in = 35'($signed(rd_data[TAP_UL]) * wx_lo)
                  + 35'($signed(rd_data[TAP_UR]) * wx_hi);
   end

   // Stage 7: blend along the rows, Q.32 result.
   logic               s7_inside_ff;
   logic signed [53:0] s7_sum_ff, s7_sum_in;
   logic signed [17:0] wy_lo, wy_hi;

   always_comb begin
      wy_hi = $signed({2'b00, s6_fy_ff});
      wy_lo = 18'sh10000 - wy_hi;
      s7_sum_in = 54'(s6_top_ff * wy_lo) + 54'(s6_bot_ff * wy_hi);
   end

   // Stage 8: round to Q.8 (ties toward plus infinity) into the output.
   rsp_payload_type    s8_ff, s8_in;
   logic signed [53:0] rounded;

   always_comb begin
      rounded = (s7_sum_ff + 54'sd8388608) >>> 24;
      s8_in.inside_res = s7_inside_ff;
      s8_in.elevation  = s7_inside_ff ? rounded[23:0] : 24'sd0;
   end

   // Valid bits; writes drop out once they reach the store.
   always_comb begin
      valid_in = valid_ff;
      if (load[1]) valid_in[1] = req_valid;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (load[k]) valid_in[k] = valid_ff[k-1];
      end
      if (load[5]) valid_in[5] = valid_ff[4] && s4_query_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s1_ff <= req_data;
      end
      if (load[2]) begin
         s2_query_ff <= s1_ff.req_type == REQ_QUERY;
         s2_addr_ff  <= s1_ff.cell_index;
         s2_value_ff <= s1_ff.cell_value;
         s2_dx_ff    <= s2_dx_in;
         s2_dy_ff    <= s2_dy_in;
      end
      if (load[3]) begin
         s3_query_ff <= s2_query_ff;
         s3_addr_ff  <= s2_addr_ff;
         s3_value_ff <= s2_value_ff;
         s3_hx_ff    <= prod_x[64:22];
         s3_hy_ff    <= prod_y[64:22];
      end
      if (load[4]) begin
         s4_query_ff  <= s3_query_ff;
         s4_addr_ff   <= s3_addr_ff;
         s4_value_ff  <= s3_value_ff;
         s4_inside_ff <= s4_inside_in;
         s4_ix_ff     <= s4_ix_in;
         s4_iy_ff     <= s4_iy_in;
         s4_ix1_ff    <= s4_ix1_in;
         s4_iy1_ff    <= s4_iy1_in;
         s4_fx_ff     <= s3_hx_ff[15:0];
         s4_fy_ff     <= s3_hy_ff[15:0];
      end
      if (load[5]) begin
         s5_inside_ff <= s4_inside_ff;
         s5_fx_ff     <= s4_fx_ff;
         s5_fy_ff     <= s4_fy_ff;
      end
      if (load[6]) begin
         s6_inside_ff <= s5_inside_ff;
         s6_fy_ff     <= s5_fy_ff;
         s6_top_ff    <= s6_top_in;
         s6_bot_ff    <= s6_bot_in;
      end
      if (load[7]) begin
         s7_inside_ff <= s6_inside_ff;
         s7_sum_ff    <= s7_sum_in;
      end
      if (load[8]) begin
         s8_ff <= s8_in;
      end
   end

   assign rsp_valid = valid_ff[NUM_STAGES];
   assign rsp_data  = s8_ff;

endmodule

`default_nettype wire

>>> tb/grid_bilinear_interpolator_tb.sv
`default_nettype none

// Testbench for the bilinear grid interpolator.
//
// An initial block programs the grid registers while the block is idle,
// then fills a queue of request beats for each phase. A clocked driver takes
// beats from that queue and presents them on the req_ channel, with a random
// gap before each one. When a beat is accepted, the driver runs it through
// the elevation predictor. For a query, the predicted response goes into a
// queue. A clocked monitor drives rsp_ready with random stalls and compares
// each response with the oldest prediction, field by field.
// The first 1024 cells are filled once after reset, and every grid used
// afterwards fits within them, so no query can read a cell that was never
// written.

module grid_bilinear_interpolator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbi_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int FILL_CELLS     = 1024;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   csr_index_type   csr_index = CSR_ORIGIN_X;
   logic [31:0]     csr_wdata = '0;

   grid_bilinear_interpolator u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The testbench's own copy of the registers and of the grid store.
   logic signed [31:0] grid_origin_x  = 32'sd0;
   logic signed [31:0] grid_origin_y  = 32'sd0;
   logic signed [31:0] grid_inv_x     = 32'sd65536;
   logic signed [31:0] grid_inv_y     = 32'sd65536;
   logic [SIZE_W-1:0]  grid_cols      = 7'd64;
   logic [SIZE_W-1:0]  grid_rows      = 7'd64;
   logic signed [15:0] grid_copy [4096];

   req_payload_type pending_beats [$];
   rsp_payload_type expected_rsp  [$];
   int errors = 0;

   // When set, the sender and the receiver run without gaps or stalls.
   bit no_idle = 1'b0;

   // Effective grid size: zero counts as one, larger values saturate.
   function automatic longint grid_size(input logic [SIZE_W-1:0] v, input int maxv);
      longint n;
      n = v;
      if (n < 1) n = 1;
      if (n > maxv) n = maxv;
      return n;
   endfunction

   // Q.16 grid position, floored, from a Q9.22 coordinate.
   function automatic longint grid_position(input logic signed [31:0] coord,
                                            input logic signed [31:0] org,
                                            input logic signed [31:0] inv);
      longint d;
      longint k;
      d = longint'(coord) - longint'(org);
      k = longint'(inv);
      return (d * k) >>> 22;
   endfunction

   function automatic longint sample_at(input longint r, input longint c, input longint n);
      logic [11:0] a;
      a = 12'((r * n + c) & 64'd4095);
      return longint'(grid_copy[a]);
   endfunction

   function automatic rsp_payload_type interpolate(input req_payload_type q);
      rsp_payload_type r;
      longint nx, ny, hx, hy, ix, iy, ix1, iy1, fx, fy, top, bot, sum, e;
      nx = grid_size(grid_cols, MAX_COLS);
      ny = grid_size(grid_rows, MAX_ROWS);
      hx = grid_position(q.longitude, grid_origin_x, grid_inv_x);
      hy = grid_position(q.latitude, grid_origin_y, grid_inv_y);
      r = '0;
      if (hx < 0 || hy < 0 || hx > nx * 65536 || hy > ny * 65536) return r;
      ix = hx >>> 16;
      iy = hy >>> 16;
      fx = hx & 65535;
      fy = hy & 65535;
      // On the inclusive upper edge the index and its neighbour both clamp.
      if (ix > nx - 1) ix = nx - 1;
      if (iy > ny - 1) iy = ny - 1;
      ix1 = (ix >= nx - 1) ? nx - 1 : ix + 1;
      iy1 = (iy >= ny - 1) ? ny - 1 : iy + 1;
      top = sample_at(iy, ix, nx) * (65536 - fx) + sample_at(iy, ix1, nx) * fx;
      bot = sample_at(iy1, ix, nx) * (65536 - fx) + sample_at(iy1, ix1, nx) * fx;
      sum = top * (65536 - fy) + bot * fy;
      // Round to nearest with ties upward; the shift floors.
      e = (sum + (64'sd1 <<< 23)) >>> 24;
      r.elevation  = e[23:0];
      r.inside_res = 1'b1;
      return r;
   endfunction

   // Updates the store copy for a write beat, or predicts the response to a query.
   task automatic predict_beat(input req_payload_type b);
      if (b.req_type == REQ_WRITE) begin
         grid_copy[b.cell_index] = b.cell_value;
      end else begin
         expected_rsp.push_back(interpolate(b));
      end
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 13);
   endfunction

   // Driver: a beat stays on the bus, unchanged, until it is accepted; then
   // the next beat waits out its own gap.
   int req_gap = 0;
   always @(posedge clock) begin
      bit busy;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         busy = req_valid;
         if (req_valid && req_ready) begin
            predict_beat(req_data);
            busy = 1'b0;
         end
         if (!busy) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               req_data <= pending_beats.pop_front();
               req_valid <= 1'b1;
               req_gap = draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted response beat is checked against the oldest
   // prediction. The receiver stalls for a random stretch after each beat.
   int rsp_stall = 0;
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response beat with nothing expected: elevation %0d inside %0b",
                        $realtime, rsp_data.elevation, rsp_data.inside_res);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.elevation !== want.elevation) begin
                  $display("%0t: elevation mismatch: expected %0d actual %0d",
                           $realtime, want.elevation, rsp_data.elevation);
                  errors++;
               end
               if (rsp_data.inside_res !== want.inside_res) begin
                  $display("%0t: inside_res mismatch: expected %0b actual %0b",
                           $realtime, want.inside_res, rsp_data.inside_res);
                  errors++;
               end
            end
            rsp_stall = draw_gap();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: a run of cycles in which no channel moves a beat means a hang.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $realtime);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Writes all six registers back to back, valid held high throughout,
   // and keeps the testbench copy in step at each accepted beat.
   task automatic program_grid(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] kx, input logic [31:0] ky,
                               input logic [31:0] nc, input logic [31:0] nr);
      logic [31:0]   vals [6];
      csr_index_type idx  [6];
      vals = '{ox, oy, kx, ky, nc, nr};
      idx  = '{CSR_ORIGIN_X, CSR_ORIGIN_Y, CSR_INV_SPACING_X, CSR_INV_SPACING_Y,
               CSR_COLS, CSR_ROWS};
      for (int i = 0; i < 6; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_ORIGIN_X:      grid_origin_x = vals[i];
            CSR_ORIGIN_Y:      grid_origin_y = vals[i];
            CSR_INV_SPACING_X: grid_inv_x    = vals[i];
            CSR_INV_SPACING_Y: grid_inv_y    = vals[i];
            CSR_COLS:          grid_cols     = vals[i][SIZE_W-1:0];
            CSR_ROWS:          grid_rows     = vals[i][SIZE_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Waits until every beat is sent and answered, then lets writes still in
   // the pipeline settle before the registers may change.
   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_payload_type write_beat(input logic [11:0] a,
                                                   input logic [15:0] v);
      req_payload_type b;
      b.req_type   = REQ_WRITE;
      b.cell_index = a;
      b.cell_value = v;
      b.longitude  = $urandom;
      b.latitude   = $urandom;
      return b;
   endfunction

   function automatic req_payload_type query_beat(input logic [31:0] lon,
                                                   input logic [31:0] lat);
      req_payload_type b;
      b.req_type   = REQ_QUERY;
      b.cell_index = $urandom;
      b.cell_value = $urandom;
      b.longitude  = lon;
      b.latitude   = lat;
      return b;
   endfunction

   // A coordinate whose grid position lands mostly inside [0, n] cells,
   // sometimes on whole cells and a little beyond either edge.
   function automatic logic [31:0] aim(input logic signed [31:0] org,
                                       input logic signed [31:0] inv, input longint n);
      longint t;
      longint d;
      if (inv == 0) return $urandom;
      t = longint'($urandom_range(0, 32'(n * 65536 + n * 8192))) - n * 4096;
      if ($urandom_range(0, 4) == 0) t = (t >>> 16) <<< 16;
      d = (t <<< 22) / longint'(inv);
      return 32'(longint'(org) + d);
   endfunction

   task automatic random_phase(input int count);
      longint nx, ny;
      int pick;
      nx = grid_size(grid_cols, MAX_COLS);
      ny = grid_size(grid_rows, MAX_ROWS);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)
            pending_beats.push_back(write_beat($urandom, $urandom));
         else if (pick < 35)
            pending_beats.push_back(query_beat($urandom, $urandom));
         else
            pending_beats.push_back(query_beat(aim(grid_origin_x, grid_inv_x, nx),
                                               aim(grid_origin_y, grid_inv_y, ny)));
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the cells that any grid below can reach, once.
      program_grid(32'd0, 32'd0, 32'd65536, 32'd65536, 32'd32, 32'd32);
      no_idle = 1'b1;
      for (int a = 0; a < FILL_CELLS; a++)
         pending_beats.push_back(write_beat(12'(a), $urandom));
      drain();
      no_idle = 1'b0;

      // Directed: sample extremes, both corners, the inclusive upper edge,
      // just past it, just below zero and the coordinate extremes.
      pending_beats.push_back(write_beat(12'd0, 16'h8000));
      pending_beats.push_back(write_beat(12'd1, 16'h7fff));
      pending_beats.push_back(write_beat(12'd32, 16'h7fff));
      pending_beats.push_back(write_beat(12'd33, 16'h8000));
      pending_beats.push_back(write_beat(12'd1023, 16'h7fff));
      pending_beats.push_back(query_beat(32'd0, 32'd0));
      pending_beats.push_back(query_beat(32'h0020_0000, 32'h0020_0000));
      pending_beats.push_back(query_beat(32'h003f_ffff, 32'h003f_ffff));
      pending_beats.push_back(query_beat(32'h0800_0000, 32'h0800_0000));
      pending_beats.push_back(query_beat(32'h0800_0000, 32'd0));
      pending_beats.push_back(query_beat(32'h0800_0040, 32'd0));
      pending_beats.push_back(query_beat(32'h07ff_ffc0, 32'h07ff_ffc0));
      pending_beats.push_back(query_beat(32'hffff_ffff, 32'd0));
      pending_beats.push_back(query_beat(32'd0, 32'hffff_ffc0));
      pending_beats.push_back(query_beat(32'h7fff_ffff, 32'h8000_0000));
      pending_beats.push_back(query_beat(32'h8000_0000, 32'h7fff_ffff));
      drain();

      // Single cell, with the size given as zero and with upper bits set.
      program_grid(32'd0, 32'd0, 32'd65536, 32'd65536, 32'hffff_ff80, 32'd1);
      pending_beats.push_back(query_beat(32'h0020_0000, 32'h0020_0000));
      pending_beats.push_back(query_beat(32'h0040_0000, 32'h0040_0000));
      pending_beats.push_back(query_beat(32'h0040_0040, 32'h0000_0000));
      random_phase(100);

      // The column count saturates while the row count keeps only its low
      // bits; fine spacing, offset origin.
      no_idle = 1'b1;
      program_grid($urandom, $urandom, 32'h0100_0000, 32'h0080_0000, 32'd127, 32'hffff_ff90);
      random_phase(150);
      no_idle = 1'b0;

      // Origin extremes with the finest spacing of either sign; the row
      // count saturates.
      program_grid(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'd8, 32'd100);
      random_phase(120);

      // Negative reciprocal spacing turns the grid round; zero reciprocal spacing pins one axis.
      program_grid(32'h0400_0000, 32'hfc00_0000, 32'hffff_0000, 32'd0, 32'd7, 32'd2);
      random_phase(120);

      // Small random sizes with random spacings and origins.
      for (int p = 0; p < 5; p++) begin
         program_grid($urandom, $urandom, $urandom_range(1024, 32'h0200_0000),
                      $urandom_range(1024, 32'h0200_0000),
                      ($urandom & 32'hffff_ff80) | $urandom_range(1, 32),
                      ($urandom & 32'hffff_ff80) | $urandom_range(1, 32));
         random_phase(100);
      end

      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d predicted responses never arrived", $realtime, expected_rsp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
rtl/gbi_pkg.sv
rtl/gbi_store.sv
rtl/grid_bilinear_interpolator.sv
tb/grid_bilinear_interpolator_tb.sv
